// File: rtl/ldwt_pkg.sv
// ldwt_pkg: shared types and constants for the longest distinct window tracker
// item structs for both channels, field widths and parameter defaults
// no dependencies
package ldwt_pkg;

	// field widths
	localparam int SYMBOL_W = 8;
	localparam int LEN_W    = 17;
	localparam int START_W  = 16;

	// parameter defaults
	localparam int MAX_STRING_DEF = 65536;
	localparam int ALPHABET_DEF   = 256;

	// one byte of the string
	typedef struct packed {
		logic [SYMBOL_W-1:0] symbol;
		logic                end_of_string;
	} byte_item_t;

	// one result per byte
	typedef struct packed {
		logic [LEN_W-1:0]   window_length;
		logic [LEN_W-1:0]   best_length;
		logic [START_W-1:0] best_start;
		logic               overflow;
		logic               string_done;
	} result_item_t;

endpackage

// File: rtl/ldwt_pos_mem.sv
// ldwt_pos_mem: last-seen position table, one write and one read port
// synchronous read with write-to-read bypass
// depends on nothing outside this file
module ldwt_pos_mem #(
	parameter int DEPTH  = 256,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic [DATA_W-1:0] byp_data_q;
	logic              byp_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, write data also kept for a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q       <= mem[rd_addr];
			byp_data_q <= wr_data;
		end
	end

	// note when the read collided with a write to the same entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (rd_en) begin
			byp_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	assign rd_data = byp_q ? byp_data_q : rd_q;

endmodule

// File: rtl/ldwt_window_core.sv
// ldwt_window_core: window start, counts, best window and seen bits
// evaluates the byte in stage one and commits the update on advance
// depends on ldwt_pkg
module ldwt_window_core #(
	parameter int MAX_STRING = ldwt_pkg::MAX_STRING_DEF,
	parameter int ALPHABET   = ldwt_pkg::ALPHABET_DEF,
	parameter int ADDR_W     = 8,
	parameter int POS_W      = 16,
	parameter int CNT_W      = 17
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  commit,
	input  logic [ADDR_W-1:0]     sym_s1,
	input  logic                  done_s1,
	input  logic [POS_W-1:0]      last_pos,
	output logic                  wr_en,
	output logic [POS_W-1:0]      wr_data,
	output ldwt_pkg::result_item_t result
);

	localparam int LEN_EXT_W   = (CNT_W > ldwt_pkg::LEN_W) ? CNT_W : ldwt_pkg::LEN_W;
	localparam int START_EXT_W = (CNT_W > ldwt_pkg::START_W) ? CNT_W : ldwt_pkg::START_W;

	logic [ALPHABET-1:0] seen_q;
	logic [CNT_W-1:0]    begin_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    best_len_q;
	logic [CNT_W-1:0]    best_begin_q;
	logic                ovf_q;

	logic                frozen;
	logic                hit;
	logic [CNT_W-1:0]    last_ext;
	logic [CNT_W-1:0]    begin_nx;
	logic [CNT_W-1:0]    cnt_nx;
	logic [CNT_W-1:0]    len_nx;
	logic                better;
	logic [CNT_W-1:0]    len_out;
	logic [CNT_W-1:0]    best_len_out;
	logic [CNT_W-1:0]    best_begin_out;
	logic [LEN_EXT_W-1:0]   len_ext;
	logic [LEN_EXT_W-1:0]   best_len_ext;
	logic [START_EXT_W-1:0] best_begin_ext;

	// window step for the byte in stage one
	always_comb begin
		frozen   = ovf_q || (cnt_q == CNT_W'(MAX_STRING));
		last_ext = CNT_W'(last_pos);
		hit      = seen_q[sym_s1] && (last_ext >= begin_q);
		begin_nx = hit ? (last_ext + CNT_W'(1)) : begin_q;
		cnt_nx   = cnt_q + CNT_W'(1);
		len_nx   = cnt_nx - begin_nx;
		better   = len_nx > best_len_q;
	end

	// result values, frozen once the string is too long
	always_comb begin
		if (frozen) begin
			len_out        = cnt_q - begin_q;
			best_len_out   = best_len_q;
			best_begin_out = best_begin_q;
		end else begin
			len_out        = len_nx;
			best_len_out   = better ? len_nx : best_len_q;
			best_begin_out = better ? begin_nx : best_begin_q;
		end
		len_ext        = LEN_EXT_W'(len_out);
		best_len_ext   = LEN_EXT_W'(best_len_out);
		best_begin_ext = START_EXT_W'(best_begin_out);
		result.window_length = len_ext[ldwt_pkg::LEN_W-1:0];
		result.best_length   = best_len_ext[ldwt_pkg::LEN_W-1:0];
		result.best_start    = best_begin_ext[ldwt_pkg::START_W-1:0];
		result.overflow      = frozen;
		result.string_done   = done_s1;
	end

	// table write of the current position
	assign wr_en   = commit && !frozen;
	assign wr_data = POS_W'(cnt_q);

	// state update, full clear after the final byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= '0;
			begin_q      <= '0;
			cnt_q        <= '0;
			best_len_q   <= '0;
			best_begin_q <= '0;
			ovf_q        <= 1'b0;
		end else if (commit) begin
			if (done_s1) begin
				seen_q       <= '0;
				begin_q      <= '0;
				cnt_q        <= '0;
				best_len_q   <= '0;
				best_begin_q <= '0;
				ovf_q        <= 1'b0;
			end else if (frozen) begin
				ovf_q <= 1'b1;
			end else begin
				seen_q[sym_s1] <= 1'b1;
				begin_q        <= begin_nx;
				cnt_q          <= cnt_nx;
				best_len_q     <= best_len_out;
				best_begin_q   <= best_begin_out;
			end
		end
	end

endmodule

// File: rtl/longest_distinct_window_tracker_unit.sv
// longest_distinct_window_tracker_unit: top level of the window tracker
// byte channel, stage one register, output register and symbol reduction
// depends on ldwt_pkg, ldwt_pos_mem and ldwt_window_core
//
// usage
//  byte channel: one byte of a string per item, end_of_string on the last
//  byte; result channel: one item per byte with the current window length,
//  best length, start of the first longest window, overflow and a copy of
//  end_of_string
//  path: a taken byte is registered in stage one, then its result in the
//  output register
//  throughput: one byte per cycle while the result channel does not stall;
//  the last-seen table is read as a byte is taken and written when it
//  commits, bypassed when the next byte reads the entry just written
//  reset: all counts, the best window and the seen bits clear at once; the
//  position table needs no clearing pass, entries count only once seen
//  receiver stall: the result holds; the byte in stage one waits behind it
//  and byte_stall rises until the result is taken
//  after the final byte all counts and seen bits clear for the next string
module longest_distinct_window_tracker_unit #(
	parameter int MAX_STRING = ldwt_pkg::MAX_STRING_DEF,
	parameter int ALPHABET   = ldwt_pkg::ALPHABET_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_stall,
	input  ldwt_pkg::byte_item_t   byte_item,
	output logic                   result_valid,
	input  logic                   result_stall,
	output ldwt_pkg::result_item_t result_item
);

	localparam int ADDR_W  = $clog2(ALPHABET);
	localparam int POS_W   = $clog2(MAX_STRING);
	localparam int CNT_W   = $clog2(MAX_STRING + 1);
	localparam int SYM_NUM = 2 ** ldwt_pkg::SYMBOL_W;

	logic [ADDR_W-1:0] sym_lut [SYM_NUM];
	logic [ADDR_W-1:0] sym_red;
	logic              advance;
	logic              accept;
	logic              commit;
	logic              s1_valid_q;
	logic [ADDR_W-1:0] sym_s1;
	logic              done_s1;
	logic [POS_W-1:0]  last_pos;
	logic              wr_en;
	logic [POS_W-1:0]  wr_data;
	ldwt_pkg::result_item_t result_s1;

	// symbol reduced into the alphabet
	for (genvar i = 0; i < SYM_NUM; i++) begin : g_sym
		assign sym_lut[i] = ADDR_W'(i % ALPHABET);
	end
	assign sym_red = sym_lut[byte_item.symbol];

	// handshake
	assign advance    = !result_valid || !result_stall;
	assign byte_stall = s1_valid_q && !advance;
	assign accept     = byte_valid && !byte_stall;
	assign commit     = s1_valid_q && advance;

	// stage one control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (commit) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			sym_s1  <= sym_red;
			done_s1 <= byte_item.end_of_string;
		end
	end

	// last-seen position table
	ldwt_pos_mem #(
		.DEPTH (ALPHABET),
		.ADDR_W(ADDR_W),
		.DATA_W(POS_W)
	) u_pos_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (accept),
		.rd_addr(sym_red),
		.rd_data(last_pos),
		.wr_en  (wr_en),
		.wr_addr(sym_s1),
		.wr_data(wr_data)
	);

	// window state and result
	ldwt_window_core #(
		.MAX_STRING(MAX_STRING),
		.ALPHABET  (ALPHABET),
		.ADDR_W    (ADDR_W),
		.POS_W     (POS_W),
		.CNT_W     (CNT_W)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (commit),
		.sym_s1  (sym_s1),
		.done_s1 (done_s1),
		.last_pos(last_pos),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.result  (result_s1)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			result_item <= result_s1;
		end
	end

endmodule

// File: tb/longest_distinct_window_tracker_unit_test.sv
`timescale 1ns / 100ps
// longest_distinct_window_tracker_unit_test: self-checking bench for the window tracker
// random byte strings with random idling on both channels, checked against a local tracker
// depends on ldwt_pkg and longest_distinct_window_tracker_unit
module longest_distinct_window_tracker_unit_test;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   byte_valid   = 1'b0;
	logic                   byte_stall;
	ldwt_pkg::byte_item_t   byte_item    = '0;
	logic                   result_valid;
	logic                   result_stall = 1'b0;
	ldwt_pkg::result_item_t result_item;

	// items waiting to be sent and results waiting to arrive
	ldwt_pkg::byte_item_t   bytes_to_send [$];
	ldwt_pkg::result_item_t window_results_due [$];

	int send_gap    = 0;
	int recv_gap    = 0;
	int idle_odds   = 0;
	bit quiet_tail  = 1'b0;
	int fault_count = 0;

	// local copy of the tracker state
	logic [15:0] seen_at [256];
	bit          seen_sym [256];
	logic [15:0] run_begin  = '0;
	logic [16:0] byte_count = '0;
	logic [16:0] top_len    = '0;
	logic [15:0] top_begin  = '0;
	bit          past_limit = 1'b0;

	logic [7:0] shuffled [256];

	longest_distinct_window_tracker_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// advance the window by one byte and work out the result it shows
	function automatic ldwt_pkg::result_item_t track_window(ldwt_pkg::byte_item_t b);
		int unsigned            sym;
		ldwt_pkg::result_item_t r;
		sym = int'(b.symbol) % ldwt_pkg::ALPHABET_DEF;
		if (past_limit || byte_count >= ldwt_pkg::MAX_STRING_DEF) begin
			past_limit = 1'b1;
		end else begin
			if (seen_sym[sym] && seen_at[sym] >= run_begin)
				run_begin = seen_at[sym] + 16'd1;
			seen_at[sym]  = byte_count[15:0];
			seen_sym[sym] = 1'b1;
			byte_count    = byte_count + 17'd1;
			// only a strictly longer window replaces the best one
			if (byte_count - {1'b0, run_begin} > top_len) begin
				top_len   = byte_count - {1'b0, run_begin};
				top_begin = run_begin;
			end
		end
		r.window_length = byte_count - {1'b0, run_begin};
		r.best_length   = top_len;
		r.best_start    = top_begin;
		r.overflow      = past_limit;
		r.string_done   = b.end_of_string;
		// last byte: clear everything but the position table
		if (b.end_of_string) begin
			foreach (seen_sym[i])
				seen_sym[i] = 1'b0;
			run_begin  = '0;
			byte_count = '0;
			top_len    = '0;
			top_begin  = '0;
			past_limit = 1'b0;
		end
		return r;
	endfunction

	task automatic push_byte(input logic [7:0] sym, input bit last);
		ldwt_pkg::byte_item_t b;
		b.symbol        = sym;
		b.end_of_string = last;
		bytes_to_send   = {bytes_to_send, b};
	endtask

	// random permutation of all byte values
	task automatic shuffle_symbols();
		int          j;
		logic [7:0]  swap;
		foreach (shuffled[i])
			shuffled[i] = 8'(i);
		for (int i = 255; i > 0; i--) begin
			j           = $urandom_range(i);
			swap        = shuffled[i];
			shuffled[i] = shuffled[j];
			shuffled[j] = swap;
		end
	endtask

	task automatic wait_drained();
		while (bytes_to_send.size() != 0 || byte_valid || window_results_due.size() != 0)
			@(negedge clk);
	endtask

	// byte channel driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_item  <= '0;
			send_gap   <= 0;
		end else begin
			if (byte_valid && !byte_stall)
				window_results_due = {window_results_due, track_window(byte_item)};
			if (!byte_valid || !byte_stall) begin
				if (send_gap != 0) begin
					send_gap   <= send_gap - 1;
					byte_valid <= 1'b0;
				end else if (bytes_to_send.size() == 0) begin
					byte_valid <= 1'b0;
				end else if (!quiet_tail && $urandom_range(99) < idle_odds) begin
					send_gap   <= $urandom_range(4);
					byte_valid <= 1'b0;
				end else begin
					byte_item  <= bytes_to_send.pop_front();
					byte_valid <= 1'b1;
				end
			end
		end
	end

	// result channel monitor and stall generator
	always @(posedge clk or negedge arst_n) begin
		ldwt_pkg::result_item_t want;
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_gap     <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (window_results_due.size() == 0) begin
					fault_count++;
					if (fault_count <= 10)
						$display("unexpected result: len %0d best %0d start %0d ovf %b done %b",
							result_item.window_length, result_item.best_length,
							result_item.best_start, result_item.overflow,
							result_item.string_done);
				end else begin
					want = window_results_due.pop_front();
					if (want.window_length !== result_item.window_length ||
							want.best_length !== result_item.best_length ||
							want.best_start !== result_item.best_start ||
							want.overflow !== result_item.overflow ||
							want.string_done !== result_item.string_done) begin
						fault_count++;
						if (fault_count <= 10)
							$display({"mismatch: expected len %0d best %0d start %0d ",
								"ovf %b done %b, got len %0d best %0d start %0d ",
								"ovf %b done %b"},
								want.window_length, want.best_length, want.best_start,
								want.overflow, want.string_done,
								result_item.window_length, result_item.best_length,
								result_item.best_start, result_item.overflow,
								result_item.string_done);
					end
				end
			end
			if (recv_gap != 0) begin
				recv_gap     <= recv_gap - 1;
				result_stall <= 1'b1;
			end else if (!quiet_tail && $urandom_range(99) < idle_odds) begin
				recv_gap     <= $urandom_range(4);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// stimulus
	initial begin
		int         random_sent;
		int         len;
		int         kind;
		int         spread;
		logic [7:0] base;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single byte, back to back repeat of the top value, ties
		idle_odds = 20;
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);
		push_byte(8'hA5, 1'b0); push_byte(8'h5A, 1'b0);
		push_byte(8'hA5, 1'b0); push_byte(8'h5A, 1'b1);
		// byte last seen before the window start must not move it
		push_byte(8'h61, 1'b0); push_byte(8'h62, 1'b0); push_byte(8'h62, 1'b0);
		push_byte(8'h61, 1'b0); push_byte(8'h63, 1'b1);
		// bytes of earlier strings count as unseen after the last byte
		push_byte(8'hFF, 1'b0); push_byte(8'h00, 1'b0); push_byte(8'h80, 1'b0);
		push_byte(8'h7F, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'hFE, 1'b0);
		push_byte(8'h00, 1'b1);

		// hold the sender until every result is back
		wait_drained();

		// random strings, a new idling mix for each
		random_sent = 0;
		while (random_sent < 1300) begin
			while (bytes_to_send.size() != 0)
				@(negedge clk);
			case ($urandom_range(2))
				0: idle_odds = 0;
				1: idle_odds = 20;
				default: idle_odds = 50;
			endcase
			kind = $urandom_range(9);
			if (kind == 9) begin
				// every byte value once, then a few repeats
				shuffle_symbols();
				len = 256 + $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					push_byte(i < 256 ? shuffled[i] : 8'($urandom_range(255)), i == len - 1);
			end else begin
				len    = (kind < 7) ? $urandom_range(1, 40) : $urandom_range(41, 300);
				base   = 8'($urandom_range(255));
				spread = ($urandom_range(1) == 0) ? $urandom_range(1, 12) : 256;
				for (int i = 0; i < len; i++)
					push_byte(base + 8'($urandom_range(spread - 1)), i == len - 1);
			end
			random_sent += len;
		end
		wait_drained();

		// tail with no idling: a full distinct run then repeats, then a short string
		quiet_tail = 1'b1;
		idle_odds  = 0;
		shuffle_symbols();
		len = 264;
		for (int i = 0; i < len; i++)
			push_byte(i < 256 ? shuffled[i] : 8'($urandom_range(255)), i == len - 1);
		for (int i = 0; i < 5; i++)
			push_byte(8'($urandom_range(255)), i == 4);

		wait_drained();
		repeat (8) @(posedge clk);
		if (window_results_due.size() != 0) begin
			fault_count += window_results_due.size();
			$display("%0d results never arrived", window_results_due.size());
		end
		if (fault_count == 0)
			$display("longest_distinct_window_tracker_unit_test: PASS");
		else
			$display("longest_distinct_window_tracker_unit_test: FAIL");
		$finish;
	end

	// hang guard
	initial begin
		#5_000_000;
		$display("longest_distinct_window_tracker_unit_test: FAIL");
		$finish;
	end

endmodule
